### hw/rtl/sprite_clip_quad_emit_assert.svh
// Assertion macros for the sprite clip block.
// Both macros expect clk in scope; SCE_ASSERT also expects rst_n.
`ifndef SPRITE_CLIP_QUAD_EMIT_ASSERT_SVH
`define SPRITE_CLIP_QUAD_EMIT_ASSERT_SVH

// Check a property while out of reset.
`define SCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/sce_pkg.sv
// ----------------------------------------------------------------------------
// sce_pkg
// Shared types and constants of the sprite clip and quad emit block.
// ----------------------------------------------------------------------------
`default_nettype none
package sce_pkg;

  localparam int SCE_QUEUE_DEPTH = 4;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_TOP    = 2'd1,
    REG_CLIP_WIDTH  = 2'd2,
    REG_CLIP_HEIGHT = 2'd3
  } reg_idx_t;

  // edge clip operations, in the order they must run
  localparam int OP_LEFT   = 0;
  localparam int OP_TOP    = 1;
  localparam int OP_RIGHT  = 2;
  localparam int OP_BOTTOM = 3;

  // classified sprite waiting for texture interpolation
  typedef struct packed {
    logic [19:0]      x;
    logic [19:0]      x2;
    logic [19:0]      y;
    logic [19:0]      y2;
    logic [15:0]      u1;
    logic [15:0]      u2;
    logic [15:0]      v1;
    logic [15:0]      v2;
    logic [31:0]      rgba;
    logic [3:0]       clip;
    logic [3:0][18:0] num;
    logic [3:0][18:0] den;
  } entry_t;

  // finished quad
  typedef struct packed {
    logic [19:0] x;
    logic [19:0] x2;
    logic [19:0] y;
    logic [19:0] y2;
    logic [15:0] u1;
    logic [15:0] u2;
    logic [15:0] v1;
    logic [15:0] v2;
    logic [31:0] rgba;
  } quad_t;

endpackage
`default_nettype wire

### hw/rtl/sce_front.sv
// ----------------------------------------------------------------------------
// sce_front
// Configuration registers, trivial reject and edge classification.
// ----------------------------------------------------------------------------
`default_nettype none
module sce_front
  import sce_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_addr,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               accept,
  input  wire logic signed [19:0] in_pos_x,
  input  wire logic signed [19:0] in_pos_y,
  input  wire logic [18:0]        in_size_w,
  input  wire logic [18:0]        in_size_h,
  input  wire logic [15:0]        in_tex_u1,
  input  wire logic [15:0]        in_tex_v1,
  input  wire logic [15:0]        in_tex_u2,
  input  wire logic [15:0]        in_tex_v2,
  input  wire logic [31:0]        in_rgba,
  output logic                    q_push,
  output entry_t                  q_data
);

  logic [15:0] clip_left_r, clip_top_r;
  logic [14:0] clip_width_r, clip_height_r;

  // write configuration; a zero size is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= '0;
      clip_top_r    <= '0;
      clip_width_r  <= '0;
      clip_height_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_CLIP_LEFT:   clip_left_r <= cfg_wdata;
        REG_CLIP_TOP:    clip_top_r  <= cfg_wdata;
        REG_CLIP_WIDTH:  if (cfg_wdata[14:0] != '0) clip_width_r <= cfg_wdata[14:0];
        REG_CLIP_HEIGHT: if (cfg_wdata[14:0] != '0) clip_height_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  logic signed [22:0] px, py, pw, ph, xe, ye, cl, ct, cr, cb;
  logic signed [22:0] nl, nt, nr, nb;
  logic               lclip, tclip, rclip, bclip, reject;

  // classify against the clip rectangle
  always_comb begin
    px = 23'(in_pos_x);
    py = 23'(in_pos_y);
    pw = $signed({4'b0, in_size_w});
    ph = $signed({4'b0, in_size_h});
    xe = px + pw;
    ye = py + ph;
    cl = 23'($signed({clip_left_r, 4'b0}));
    ct = 23'($signed({clip_top_r, 4'b0}));
    cr = cl + $signed({4'b0, clip_width_r, 4'b0});
    cb = ct + $signed({4'b0, clip_height_r, 4'b0});
    reject = (xe < cl) || (px > cr) || (ye < ct) || (py > cb);
    lclip = px < cl;
    tclip = py < ct;
    rclip = xe > cr;
    bclip = ye > cb;
    nl = cl - px;
    nt = ct - py;
    nr = xe - cr;
    nb = ye - cb;

    q_data.x    = lclip ? cl[19:0] : px[19:0];
    q_data.y    = tclip ? ct[19:0] : py[19:0];
    q_data.x2   = rclip ? cr[19:0] : xe[19:0];
    q_data.y2   = bclip ? cb[19:0] : ye[19:0];
    q_data.u1   = in_tex_u1;
    q_data.u2   = in_tex_u2;
    q_data.v1   = in_tex_v1;
    q_data.v2   = in_tex_v2;
    q_data.rgba = in_rgba;
    q_data.clip = '0;
    q_data.clip[OP_LEFT]   = lclip;
    q_data.clip[OP_TOP]    = tclip;
    q_data.clip[OP_RIGHT]  = rclip;
    q_data.clip[OP_BOTTOM] = bclip;
    q_data.num[OP_LEFT]    = nl[18:0];
    q_data.num[OP_TOP]     = nt[18:0];
    q_data.num[OP_RIGHT]   = nr[18:0];
    q_data.num[OP_BOTTOM]  = nb[18:0];
    // right and bottom scale against the span left after left and top
    q_data.den[OP_LEFT]    = in_size_w;
    q_data.den[OP_TOP]     = in_size_h;
    q_data.den[OP_RIGHT]   = lclip ? in_size_w - nl[18:0] : in_size_w;
    q_data.den[OP_BOTTOM]  = tclip ? in_size_h - nt[18:0] : in_size_h;
  end

  assign q_push = accept && !reject;

endmodule
`default_nettype wire

### hw/rtl/sce_fifo.sv
// ----------------------------------------------------------------------------
// sce_fifo
// Short queue of classified sprites between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module sce_fifo
  import sce_pkg::*;
#(
  parameter int DEPTH = SCE_QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t wdata,
  input  wire logic   pop,
  output entry_t      rdata,
  output logic        full,
  output logic        not_empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign full      = count_r == CW'(DEPTH);
  assign not_empty = count_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem_r[rd_ptr_r];

  // store entries
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sce_back.sv
// ----------------------------------------------------------------------------
// sce_back
// Texture interpolation: one multiplier and a bit-serial divider shared by
// the four clipped edges.
// ----------------------------------------------------------------------------
`default_nettype none
module sce_back
  import sce_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_valid,
  input  wire entry_t q_data,
  output logic        q_pop,
  output logic        quad_valid,
  output quad_t       quad,
  input  wire logic   quad_take
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  entry_t      ent_r;
  logic [3:0]  mask_r;
  logic [1:0]  op_r;
  logic [34:0] prod_r;
  logic        neg_r;
  logic [18:0] den_r, rem_r;
  logic [14:0] q_r;
  logic [3:0]  cnt_r;

  logic [1:0]         op_sel;
  logic signed [16:0] span;
  logic [15:0]        mag;
  logic [18:0]        rem_cur;
  logic [19:0]        shifted, trial;
  logic               qbit;
  logic [15:0]        quo;
  logic signed [16:0] delta;
  logic [15:0]        new_lo, new_hi;
  logic               load;

  // pick the first pending edge
  always_comb begin
    if (mask_r[OP_LEFT])      op_sel = 2'(OP_LEFT);
    else if (mask_r[OP_TOP])  op_sel = 2'(OP_TOP);
    else if (mask_r[OP_RIGHT]) op_sel = 2'(OP_RIGHT);
    else                      op_sel = 2'(OP_BOTTOM);
  end

  // span of the selected axis, sign and magnitude
  always_comb begin
    if (op_sel[0]) span = $signed({1'b0, ent_r.v2}) - $signed({1'b0, ent_r.v1});
    else           span = $signed({1'b0, ent_r.u2}) - $signed({1'b0, ent_r.u1});
    mag = span[16] ? 16'(-span) : span[15:0];
  end

  // one restoring divide step
  always_comb begin
    rem_cur = (cnt_r == '0) ? prod_r[34:16] : rem_r;
    shifted = {rem_cur, prod_r[4'd15 - cnt_r]};
    trial   = shifted - {1'b0, den_r};
    qbit    = !trial[19];
    quo     = (den_r == '0) ? '0 : {q_r, qbit};
    delta   = neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (op_r[0]) begin
      new_lo = 16'($signed({1'b0, ent_r.v1}) + delta);
      new_hi = 16'($signed({1'b0, ent_r.v2}) - delta);
    end else begin
      new_lo = 16'($signed({1'b0, ent_r.u1}) + delta);
      new_hi = 16'($signed({1'b0, ent_r.u2}) - delta);
    end
  end

  assign quad_valid = state_r == ST_DONE;
  assign load  = q_valid && (state_r == ST_IDLE || (state_r == ST_DONE && quad_take));
  assign q_pop = load;

  // sequence the edges
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (load) state_nxt = (q_data.clip == '0) ? ST_DONE : ST_MUL;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == 4'd15) state_nxt = ((mask_r & ~(4'b1 << op_r)) == '0) ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (load)           state_nxt = (q_data.clip == '0) ? ST_DONE : ST_MUL;
        else if (quad_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (load) begin
      ent_r  <= q_data;
      mask_r <= q_data.clip;
    end else if (state_r == ST_MUL) begin
      op_r   <= op_sel;
      prod_r <= 35'(mag) * 35'(ent_r.num[op_sel]);
      neg_r  <= span[16];
      den_r  <= ent_r.den[op_sel];
      cnt_r  <= '0;
    end else if (state_r == ST_DIV) begin
      rem_r <= qbit ? trial[18:0] : shifted[18:0];
      q_r   <= {q_r[13:0], qbit};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == 4'd15) begin
        mask_r[op_r] <= 1'b0;
        unique case (op_r)
          2'(OP_LEFT):   ent_r.u1 <= new_lo;
          2'(OP_TOP):    ent_r.v1 <= new_lo;
          2'(OP_RIGHT):  ent_r.u2 <= new_hi;
          default:       ent_r.v2 <= new_hi;
        endcase
      end
    end
  end

  assign quad.x    = ent_r.x;
  assign quad.x2   = ent_r.x2;
  assign quad.y    = ent_r.y;
  assign quad.y2   = ent_r.y2;
  assign quad.u1   = ent_r.u1;
  assign quad.u2   = ent_r.u2;
  assign quad.v1   = ent_r.v1;
  assign quad.v2   = ent_r.v2;
  assign quad.rgba = ent_r.rgba;

endmodule
`default_nettype wire

### hw/rtl/sce_emit.sv
// ----------------------------------------------------------------------------
// sce_emit
// Holds one finished quad and presents its four strip vertices in turn.
// ----------------------------------------------------------------------------
`default_nettype none
module sce_emit
  import sce_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         quad_valid,
  input  wire quad_t        quad,
  output logic              quad_take,
  input  wire logic         pop,
  output logic              empty,
  output logic signed [19:0] out_vert_x,
  output logic signed [19:0] out_vert_y,
  output logic [15:0]       out_vert_u,
  output logic [15:0]       out_vert_v,
  output logic [31:0]       out_vert_rgba,
  output logic [1:0]        out_corner,
  output logic              out_last
);

  `include "sprite_clip_quad_emit_assert.svh"

  quad_t      quad_r;
  logic       busy_r;
  logic [1:0] corner_r;
  logic       done;

  assign done      = busy_r && pop && (corner_r == 2'd3);
  assign quad_take = !busy_r || done;

  // load a quad, advance corners on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      corner_r <= '0;
    end else if (quad_take) begin
      busy_r   <= quad_valid;
      corner_r <= '0;
    end else if (pop) begin
      corner_r <= corner_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (quad_take && quad_valid) quad_r <= quad;
  end

  assign empty         = !busy_r;
  assign out_vert_x    = corner_r[1] ? quad_r.x2 : quad_r.x;
  assign out_vert_y    = corner_r[0] ? quad_r.y2 : quad_r.y;
  assign out_vert_u    = corner_r[1] ? quad_r.u2 : quad_r.u1;
  assign out_vert_v    = corner_r[0] ? quad_r.v2 : quad_r.v1;
  assign out_vert_rgba = quad_r.rgba;
  assign out_corner    = corner_r;
  assign out_last      = corner_r == 2'd3;

  `SCE_ASSERT(a_corner_step, busy_r && pop && corner_r != 2'd3 |=> busy_r && corner_r == $past(corner_r) + 2'd1, "corner did not advance")
  `SCE_ASSERT(a_hold_stall, busy_r && !pop |=> busy_r && $stable(corner_r), "vertex dropped while stalled")
  `SCE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !busy_r && corner_r == 2'd0, "not empty after reset")

endmodule
`default_nettype wire

### hw/rtl/sprite_clip_quad_emit.sv
// ----------------------------------------------------------------------------
// sprite_clip_quad_emit
// Clips axis-aligned sprites to a rectangle and emits four strip vertices.
// ----------------------------------------------------------------------------
// Usage: push one sprite on the in_ ports while full is low. A sprite wholly
// outside the clip rectangle is dropped; any other yields four vertices on
// the out_ ports, corners 0..3, out_last on the fourth. A vertex is taken
// with pop while empty is low. Write the clip registers over cfg_ only while
// the block is idle.
// An unclipped sprite passes through the queue, the back's entry register and
// the emit quad register before its first vertex shows. Each clipped edge
// also passes the shared multiply and bit-serial divide unit: a multiply,
// then 16 divide steps. Sprites leave at the pace of the single result port,
// which gives four vertices per quad; clipped edges add divider work.
// A queue of QUEUE_DEPTH sprites lets the front keep accepting while the
// divider works. When pop is held low the current vertex holds, the back
// completes one more quad, then the queue fills and full rises.
// Reset clears the clip rectangle to the point (0,0) and empties all stages.
// ----------------------------------------------------------------------------
`default_nettype none
module sprite_clip_quad_emit
  import sce_pkg::*;
#(
  parameter int QUEUE_DEPTH = SCE_QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_addr,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [19:0] in_pos_x,
  input  wire logic signed [19:0] in_pos_y,
  input  wire logic [18:0]        in_size_w,
  input  wire logic [18:0]        in_size_h,
  input  wire logic [15:0]        in_tex_u1,
  input  wire logic [15:0]        in_tex_v1,
  input  wire logic [15:0]        in_tex_u2,
  input  wire logic [15:0]        in_tex_v2,
  input  wire logic [31:0]        in_rgba,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [19:0]      out_vert_x,
  output logic signed [19:0]      out_vert_y,
  output logic [15:0]             out_vert_u,
  output logic [15:0]             out_vert_v,
  output logic [31:0]             out_vert_rgba,
  output logic [1:0]              out_corner,
  output logic                    out_last
);

  logic   q_push, q_pop, q_valid, quad_valid, quad_take;
  entry_t q_wdata, q_rdata;
  quad_t  quad;

  sce_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .accept (push && !full),
    .in_pos_x, .in_pos_y, .in_size_w, .in_size_h,
    .in_tex_u1, .in_tex_v1, .in_tex_u2, .in_tex_v2, .in_rgba,
    .q_push, .q_data (q_wdata)
  );

  sce_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk, .rst_n, .push (q_push), .wdata (q_wdata), .pop (q_pop),
    .rdata (q_rdata), .full, .not_empty (q_valid)
  );

  sce_back u_back (
    .clk, .rst_n, .q_valid, .q_data (q_rdata), .q_pop,
    .quad_valid, .quad, .quad_take
  );

  sce_emit u_emit (
    .clk, .rst_n, .quad_valid, .quad, .quad_take, .pop, .empty,
    .out_vert_x, .out_vert_y, .out_vert_u, .out_vert_v, .out_vert_rgba,
    .out_corner, .out_last
  );

endmodule
`default_nettype wire
